// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, masked while reset is low
`define KHS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// property checked on every rising edge, reset included
`define KHS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/khs_pkg.sv =====
// shared types, request codes and helpers of the key history stack
package khs_pkg;

    localparam int KEY_W   = 64;
    localparam int REQ_W   = 3;
    localparam int RES_W   = 8;
    localparam int CHUNK_W = 16;
    localparam int CHUNK_CNT_W = $clog2(CHUNK_W + 1);

    localparam logic [REQ_W-1:0] REQ_PUSH      = 3'd0;
    localparam logic [REQ_W-1:0] REQ_POP       = 3'd1;
    localparam logic [REQ_W-1:0] REQ_COUNT     = 3'd2;
    localparam logic [REQ_W-1:0] REQ_COUNT_TOP = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR     = 3'd4;

    // shift control broadcast to every cell of the chain
    typedef struct packed {
        logic shift_in;   // push: take the newer neighbor's key
        logic shift_out;  // pop: take the older neighbor's key
    } t_cell_ctl;

    function automatic logic [CHUNK_CNT_W-1:0] popcount_chunk(input logic [CHUNK_W-1:0] bits);
        logic [CHUNK_CNT_W-1:0] sum;
        sum = '0;
        for (int i = 0; i < CHUNK_W; i++) begin
            sum = sum + CHUNK_CNT_W'(bits[i]);
        end
        return sum;
    endfunction

endpackage

// ===== hw/rtl/khs_cell.sv =====
// one stack slot: key register, neighbor shift and registered match flag
module khs_cell #(
    parameter int DEPTH = 128,
    parameter int IDX   = 0
) (
    input  logic                       i_clk,
    input  khs_pkg::t_cell_ctl         i_ctl,
    input  logic [khs_pkg::KEY_W-1:0]  i_newer_key,
    input  logic [khs_pkg::KEY_W-1:0]  i_older_key,
    input  logic [khs_pkg::KEY_W-1:0]  i_cmp_key,
    input  logic [$clog2(DEPTH+1)-1:0] i_fill,
    output logic [khs_pkg::KEY_W-1:0]  o_key,
    output logic                       o_match
);
    import khs_pkg::*;

    localparam int FW = $clog2(DEPTH + 1);

    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] n_key;
    logic             r_match;
    logic             n_match;

    always_comb begin
        n_key = r_key;
        if (i_ctl.shift_in) begin
            n_key = i_newer_key;
        end else if (i_ctl.shift_out) begin
            n_key = i_older_key;
        end
    end

    // only slots below the fill level hold live entries
    assign n_match = (r_key == i_cmp_key) && (i_fill > FW'(IDX));

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_match <= n_match;
    end

    assign o_key   = r_key;
    assign o_match = r_match;

endmodule

// ===== hw/rtl/khs_popcnt.sv =====
// chunked population count over the cells' match flags
module khs_popcnt #(
    parameter int DEPTH = 128
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [((DEPTH + khs_pkg::CHUNK_W - 1) / khs_pkg::CHUNK_W) * khs_pkg::CHUNK_W - 1:0]
                                       i_bits,
    output logic                       o_done,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    import khs_pkg::*;

    localparam int NCHUNK = (DEPTH + CHUNK_W - 1) / CHUNK_W;
    localparam int IW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int CW     = $clog2(DEPTH + 1);

    logic          r_busy;
    logic          r_done;
    logic [IW-1:0] r_idx;
    logic [CW-1:0] r_acc;
    logic [CHUNK_W-1:0] w_chunk;
    logic          w_last;

    assign w_chunk = i_bits[r_idx * CHUNK_W +: CHUNK_W];
    assign w_last  = (r_idx == IW'(NCHUNK - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && w_last) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_idx <= '0;
            r_acc <= '0;
        end else if (r_busy) begin
            r_idx <= r_idx + IW'(1);
            r_acc <= r_acc + CW'(popcount_chunk(w_chunk));
        end
    end

    assign o_done  = r_done;
    assign o_count = r_acc;

endmodule

// ===== hw/rtl/key_history_stack_match_count.sv =====
// top level of the key history stack with match counting
//
// a bounded stack of 64-bit position keys built as a chain of cells, the
// newest key in cell 0. one request word enters on the slave stream:
// s_tuser carries the request code, s_tdata the key. one result word leaves
// on the master stream with the match count and the fill level after the
// request. push, pop, clear and unknown codes answer with a match count of 0.
// push on a full stack drops the oldest key at the far end of the chain.
//
// sequencing: one request at a time. push, pop, clear and unknown codes go
// from accept straight to the result stage. a count first has every cell
// register its compare, then the popcount unit sums the match flags 16 per
// cycle and hands the sum to the result stage. count-top on an empty stack
// skips the compare and goes straight to the result stage.
//
// s_tready is high whenever no request is in progress, also while a result
// waits in the output register; a stalled receiver holds the result there
// and the next request waits for the slot to free up.
// reset empties the stack at once (fill level 0); stale keys are never read.
module key_history_stack_match_count #(
    parameter int DEPTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] key
    input  logic [7:0]  s_tuser,   // [2:0] req_type, [7:3] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [7:0] match_count, [15:8] fill_level
);
    import khs_pkg::*;

    localparam int FW     = $clog2(DEPTH + 1);
    localparam int NCHUNK = (DEPTH + CHUNK_W - 1) / CHUNK_W;
    localparam int NPAD   = NCHUNK * CHUNK_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_SUM  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [FW-1:0]    r_fill;
    logic [FW-1:0]    n_fill;
    logic [KEY_W-1:0] r_cmp_key;
    logic [RES_W-1:0] r_res_match;
    logic [RES_W-1:0] n_res_match;
    logic             r_out_valid;
    logic [15:0]      r_out_data;

    logic             w_accept;
    logic [REQ_W-1:0] w_req;
    logic             w_out_free;
    t_cell_ctl        w_ctl;
    logic [KEY_W-1:0] w_key [DEPTH];
    logic [NPAD-1:0]  w_match;
    logic             w_pc_done;
    logic [FW-1:0]    w_pc_count;

    assign w_req      = s_tuser[REQ_W-1:0];
    assign s_tready   = (r_state == S_IDLE);
    assign w_accept   = s_tvalid && s_tready;
    assign w_out_free = !r_out_valid || m_tready;

    // stack moves: push shifts toward the old end, a pop on a live stack back
    always_comb begin
        w_ctl  = '0;
        n_fill = r_fill;
        if (w_accept) begin
            case (w_req)
                REQ_PUSH: begin
                    w_ctl.shift_in = 1'b1;
                    if (r_fill != FW'(DEPTH)) begin
                        n_fill = r_fill + FW'(1);
                    end
                end
                REQ_POP: begin
                    if (r_fill != '0) begin
                        w_ctl.shift_out = 1'b1;
                        n_fill = r_fill - FW'(1);
                    end
                end
                REQ_CLEAR: n_fill = '0;
                default:   n_fill = r_fill;
            endcase
        end
    end

    // request sequencing
    always_comb begin
        n_state     = r_state;
        n_res_match = r_res_match;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_res_match = '0;
                    if (w_req == REQ_COUNT) begin
                        n_state = S_CMP;
                    end else if (w_req == REQ_COUNT_TOP && r_fill != '0) begin
                        n_state = S_CMP;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_CMP: n_state = S_SUM;
            S_SUM: begin
                if (w_pc_done) begin
                    n_res_match = RES_W'(w_pc_count);
                    n_state     = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_res_match <= n_res_match;
        if (w_accept) begin
            // count-top compares against the key in the newest cell
            r_cmp_key <= (w_req == REQ_COUNT_TOP) ? w_key[0] : s_tdata;
        end
        if (r_state == S_DONE && w_out_free) begin
            r_out_data <= {RES_W'(r_fill), r_res_match};
        end
    end

    // chain of cells, cell 0 holds the newest key
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic [KEY_W-1:0] w_newer;
        logic [KEY_W-1:0] w_older;

        if (gi == 0) begin : g_head
            assign w_newer = s_tdata;
        end else begin : g_body
            assign w_newer = w_key[gi-1];
        end
        if (gi == DEPTH - 1) begin : g_tail
            assign w_older = '0;
        end else begin : g_inner
            assign w_older = w_key[gi+1];
        end

        khs_cell #(
            .DEPTH (DEPTH),
            .IDX   (gi)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_newer_key (w_newer),
            .i_older_key (w_older),
            .i_cmp_key   (r_cmp_key),
            .i_fill      (r_fill),
            .o_key       (w_key[gi]),
            .o_match     (w_match[gi])
        );
    end

    // unused padding of the last chunk counts as no match
    if (NPAD > DEPTH) begin : g_pad
        assign w_match[NPAD-1:DEPTH] = '0;
    end

    khs_popcnt #(
        .DEPTH (DEPTH)
    ) u_popcnt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_CMP),
        .i_bits  (w_match),
        .o_done  (w_pc_done),
        .o_count (w_pc_count)
    );

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

endmodule

// ===== hw/rtl/khs_checker.sv =====
// port-level checks of the key history stack, bound to the top level
`include "assert_macros.svh"

module khs_checker #(
    parameter int DEPTH = 128
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    logic       w_in_take;
    logic       w_out_stall;
    logic [7:0] w_match;
    logic [7:0] w_fill;

    assign w_in_take   = s_tvalid && s_tready;
    assign w_out_stall = m_tvalid && !m_tready;
    assign w_match     = m_tdata[7:0];
    assign w_fill      = m_tdata[15:8];

    // no result word right after reset
    `KHS_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !m_tvalid, "result word after reset")

    // a stalled result word holds
    `KHS_ASSERT(a_out_hold, i_clk, i_rst_n, w_out_stall |=> (m_tvalid && $stable(m_tdata)),
                "stalled result changed")

    // one request at a time: a taken word closes the input for the next cycle
    `KHS_ASSERT(a_one_req, i_clk, i_rst_n, w_in_take |=> !s_tready, "input open after accept")

    // fill level never passes the stack depth
    `KHS_ASSERT(a_fill_max, i_clk, i_rst_n, m_tvalid |-> ((DEPTH > 255) || (w_fill <= 8'(DEPTH))),
                "fill level above depth")

    // matches come only from held entries
    `KHS_ASSERT(a_match_max, i_clk, i_rst_n, m_tvalid |-> ((DEPTH > 255) || (w_match <= w_fill)),
                "match count above fill level")

endmodule

bind key_history_stack_match_count khs_checker #(.DEPTH(DEPTH)) u_khs_checker (.*);

// ===== bench/tb.sv =====
// self-checking bench for the key history stack: directed, full-stack, stall and random requests
module tb;
    import khs_pkg::*;

    localparam int DEPTH = 128;

    // request codes past clear that the block must ignore
    localparam logic [REQ_W-1:0] REQ_UNUSED_MIN = REQ_CLEAR + 3'd1;
    localparam logic [REQ_W-1:0] REQ_UNUSED_MAX = 3'h7;

    typedef struct packed {
        logic [RES_W-1:0] match_count;
        logic [RES_W-1:0] fill_level;
    } t_stack_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;   // [63:0] key
    logic [7:0]  s_tuser = '0;   // [2:0] req_type, [7:3] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // [7:0] match_count, [15:8] fill_level

    // predicted stack contents, bottom at index 0
    logic [KEY_W-1:0] held_keys [DEPTH];
    int unsigned      held_count;

    t_stack_result    pending_results [$];

    int unsigned requests_sent;
    int unsigned results_checked;
    int unsigned mismatch_count;
    int unsigned full_pushes;
    int unsigned peak_fill;

    // idle gaps on both sides, and a one-off long stall for the receiver
    bit          gaps_on = 1'b1;
    int unsigned hold_off_cycles;

    key_history_stack_match_count #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // number of held entries equal to a key
    function automatic int unsigned count_held(input logic [KEY_W-1:0] key);
        int unsigned n;
        n = 0;
        for (int i = 0; i < held_count; i++) begin
            if (held_keys[i] == key) begin
                n++;
            end
        end
        return n;
    endfunction

    // apply one request to the predicted stack and return its result word
    function automatic t_stack_result predict_request(input logic [REQ_W-1:0] req,
                                                      input logic [KEY_W-1:0] key);
        t_stack_result res;
        int unsigned   n;
        n = 0;
        case (req)
            REQ_PUSH: begin
                // full stack: oldest key falls off the bottom
                if (held_count == DEPTH) begin
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        held_keys[i] = held_keys[i + 1];
                    end
                    held_count = DEPTH - 1;
                    full_pushes++;
                end
                held_keys[held_count] = key;
                held_count++;
            end
            REQ_POP: begin
                if (held_count > 0) begin
                    held_count--;
                end
            end
            REQ_COUNT: begin
                n = count_held(key);
            end
            REQ_COUNT_TOP: begin
                // empty stack counts nothing
                if (held_count > 0) begin
                    n = count_held(held_keys[held_count - 1]);
                end
            end
            REQ_CLEAR: begin
                held_count = 0;
            end
            default: begin
                // unused codes leave the stack alone
            end
        endcase
        if (held_count > peak_fill) begin
            peak_fill = held_count;
        end
        res.match_count = RES_W'(n);
        res.fill_level  = RES_W'(held_count);
        return res;
    endfunction

    // offer one request word, after a random gap while gaps are on, and wait for it to be taken
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [KEY_W-1:0] key);
        int unsigned gap;
        gap = gaps_on ? $urandom_range(0, 11) : 0;
        // valid stays up across back-to-back words
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= key;
        s_tuser  <= {5'b0, req};
        do @(posedge i_clk); while (!s_tready);
        pending_results.push_back(predict_request(req, key));
        requests_sent++;
    endtask

    // receiver: random ready gaps, plus the long hold-off when one is armed
    initial begin
        int unsigned stall;
        forever begin
            if (hold_off_cycles > 0) begin
                stall = hold_off_cycles;
                hold_off_cycles = 0;
            end else begin
                stall = gaps_on ? $urandom_range(0, 11) : 0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
        end
    end

    // each result word against the oldest prediction
    always @(posedge i_clk) begin
        t_stack_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result word: match_count %0d, fill_level %0d",
                       m_tdata[7:0], m_tdata[15:8]);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (m_tdata[7:0] !== want.match_count) begin
                    $error("match_count: expected %0d, got %0d", want.match_count,
                           m_tdata[7:0]);
                    mismatch_count++;
                end
                if (m_tdata[15:8] !== want.fill_level) begin
                    $error("fill_level: expected %0d, got %0d", want.fill_level,
                           m_tdata[15:8]);
                    mismatch_count++;
                end
            end
        end
    end

    // corner requests on a small stack: empty cases, key extremes, unused codes
    task automatic test_directed();
        send_request(REQ_POP, '0);                      // pop on empty
        send_request(REQ_COUNT_TOP, '1);                // count-top on empty
        send_request(REQ_COUNT, '0);                    // count on empty
        send_request(REQ_PUSH, '0);
        send_request(REQ_PUSH, '1);
        send_request(REQ_PUSH, '1);
        send_request(REQ_COUNT, '1);
        send_request(REQ_COUNT, '0);
        send_request(REQ_COUNT_TOP, '0);
        send_request(REQ_COUNT, 64'h8000_0000_0000_0001);
        send_request(REQ_POP, '1);
        send_request(REQ_COUNT_TOP, '1);
        for (int c = REQ_UNUSED_MIN; c <= REQ_UNUSED_MAX; c++) begin
            send_request(REQ_W'(c), 64'hA5A5_5A5A_F00F_0FF0);
        end
        send_request(REQ_PUSH, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(REQ_PUSH, 64'h5555_5555_5555_5555);
        send_request(REQ_COUNT, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(REQ_COUNT, 64'h5555_5555_5555_5555);
        send_request(REQ_CLEAR, '1);
        send_request(REQ_COUNT_TOP, '0);
        send_request(REQ_POP, '0);
    endtask

    // overflow shift-out, a count of DEPTH, then drain past empty
    task automatic test_full_stack();
        logic [KEY_W-1:0] base;
        logic [KEY_W-1:0] same_key;
        base     = {$urandom, $urandom};
        same_key = {$urandom, $urandom};
        gaps_on  = 1'b0;
        for (int i = 0; i < DEPTH + 2; i++) begin
            send_request(REQ_PUSH, base + KEY_W'(i));
        end
        // the two oldest keys are gone; checked on the oldest, then base + 2 and the newest are still held
        send_request(REQ_COUNT, base);
        send_request(REQ_COUNT, base + 64'd2);
        send_request(REQ_COUNT, base + KEY_W'(DEPTH + 1));
        send_request(REQ_CLEAR, '0);
        gaps_on = 1'b1;
        for (int i = 0; i < DEPTH + 2; i++) begin
            send_request(REQ_PUSH, same_key);
        end
        send_request(REQ_COUNT, same_key);
        send_request(REQ_COUNT_TOP, '0);
        send_request(REQ_PUSH, ~same_key);
        send_request(REQ_COUNT, same_key);
        gaps_on = 1'b0;
        for (int i = 0; i < DEPTH + 1; i++) begin
            send_request(REQ_POP, '0);
        end
        send_request(REQ_COUNT_TOP, same_key);
        gaps_on = 1'b1;
    endtask

    // receiver stalls for a long stretch while words keep coming
    task automatic test_stalled_receiver();
        logic [KEY_W-1:0] key;
        key = {$urandom, $urandom};
        hold_off_cycles = 250;
        gaps_on = 1'b0;
        for (int i = 0; i < 24; i++) begin
            case (i % 3)
                0:       send_request(REQ_PUSH, key);
                1:       send_request(REQ_COUNT, key);
                default: send_request(REQ_COUNT_TOP, '0);
            endcase
        end
        gaps_on = 1'b1;
    endtask

    // phases of mixed traffic over a small key pool so that counts hit
    task automatic test_random_traffic(input int unsigned target);
        logic [KEY_W-1:0] key_pool [8];
        logic [KEY_W-1:0] key;
        logic [REQ_W-1:0] req;
        int unsigned      push_pct;
        int unsigned      pop_pct;
        int unsigned      clear_pct;
        int unsigned      r;
        while (requests_sent < target) begin
            gaps_on   = ($urandom_range(0, 3) != 0);
            push_pct  = $urandom_range(25, 60);
            pop_pct   = $urandom_range(5, 25);
            clear_pct = 3 * $urandom_range(0, 1);
            key_pool[0] = '0;
            key_pool[1] = '1;
            for (int i = 2; i < 8; i++) begin
                key_pool[i] = {$urandom, $urandom};
            end
            repeat ($urandom_range(40, 160)) begin
                r   = $urandom_range(0, 99);
                key = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                                  : key_pool[$urandom_range(0, 7)];
                if (r < push_pct) begin
                    req = REQ_PUSH;
                end else if (r < push_pct + pop_pct) begin
                    req = REQ_POP;
                end else if (r < push_pct + pop_pct + clear_pct) begin
                    req = REQ_CLEAR;
                end else if (r >= 97) begin
                    req = REQ_W'($urandom_range(REQ_UNUSED_MIN, REQ_UNUSED_MAX));
                end else if (r % 2 == 1) begin
                    req = REQ_COUNT;
                end else begin
                    req = REQ_COUNT_TOP;
                end
                send_request(req, key);
            end
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        held_count = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_stack();
        test_stalled_receiver();
        test_random_traffic(1350);

        // drop valid, drain the outstanding results, then settle
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (30) @(posedge i_clk);

        $display("%0d requests with %0d result words checked, %0d pushes on a full stack",
                 requests_sent, results_checked, full_pushes);
        $display("peak fill level %0d of %0d", peak_fill, DEPTH);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // run limit well above the slowest correct run
    initial begin
        #(12 * 400000);
        $display("Verification failed");
        $finish;
    end

endmodule
